>>> sv/triangle_scanline_span_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the triangle scanline span unit checker.
// Both macros expect clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_SCANLINE_SPAN_UNIT_ASSERT_SVH
`define TRIANGLE_SCANLINE_SPAN_UNIT_ASSERT_SVH

// property that holds at every edge out of reset
`define TSS_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define TSS_CHECK_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> sv/tss_pkg.sv
// ---------------------------------------------------------------------------
// tss_pkg
// Shared types for the triangle scanline span pipeline.
// ---------------------------------------------------------------------------
package tss_pkg;

    // control that travels alongside each transaction
    typedef struct packed {
        logic vld;  // stage holds a transaction
        logic hit;  // row lies inside the triangle
    } ctl_t;

endpackage

>>> sv/triangle_scanline_span_unit.sv
// ---------------------------------------------------------------------------
// triangle_scanline_span_unit
// Span of one scanline of a filled triangle.
// ---------------------------------------------------------------------------
// Usage:
//   Input: drive the three vertices and row_offset with start high; the
//   transaction is taken at the clock edge where start is high and busy is
//   low. busy is held low, so a transaction can be issued on every clock.
//   Output: done pulses for one cycle with span_left, span_right, span_row and
//   span_valid. The receiver has no backpressure; results must be taken when
//   done is high. span_valid low means the row is outside the triangle, and
//   the other fields read zero.
//   Path from start to done: sort, edge setup, multiply, the two-lane
//   pipelined divider, floor correction, ordering.
//   Throughput: one transaction per clock, set by the fully pipelined divider.
//   Reset: rst_n clears every valid bit; transactions in flight are dropped
//   and done stays low until new transactions arrive.
// ---------------------------------------------------------------------------
module triangle_scanline_span_unit #(
    parameter int COORD_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_BITS-1:0] vert_a_x,
    input  logic [COORD_BITS-1:0] vert_a_y,
    input  logic [COORD_BITS-1:0] vert_b_x,
    input  logic [COORD_BITS-1:0] vert_b_y,
    input  logic [COORD_BITS-1:0] vert_c_x,
    input  logic [COORD_BITS-1:0] vert_c_y,
    input  logic [COORD_BITS-1:0] row_offset,
    output logic                  done,
    output logic [COORD_BITS-1:0] span_left,
    output logic [COORD_BITS-1:0] span_right,
    output logic [COORD_BITS-1:0] span_row,
    output logic                  span_valid
);

    import tss_pkg::*;

    localparam int N      = COORD_BITS;
    localparam int SIDE_W = 3 * N + 2;

    logic         srt_vld;
    logic [N-1:0] x0, y0, x1, y1, x2, y2, srt_off;

    ctl_t           setup_ctl;
    logic [2*N-1:0] prod_l, prod_r;
    logic [N-1:0]   den_l, den_r, xs_l, xs_r, row;
    logic           neg_l, neg_r;

    ctl_t              div_ctl;
    logic [1:0][N-1:0] div_quo, div_rem;
    logic [SIDE_W-1:0] div_side;

    // pipeline never stalls
    assign busy = 1'b0;

    tss_sort #(.N(N)) u_sort (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (start & ~busy),
        .ax      (vert_a_x),
        .ay      (vert_a_y),
        .bx      (vert_b_x),
        .by      (vert_b_y),
        .cx      (vert_c_x),
        .cy      (vert_c_y),
        .off     (row_offset),
        .out_vld (srt_vld),
        .x0      (x0),
        .y0      (y0),
        .x1      (x1),
        .y1      (y1),
        .x2      (x2),
        .y2      (y2),
        .out_off (srt_off)
    );

    tss_edge_setup #(.N(N)) u_setup (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (srt_vld),
        .x0      (x0),
        .y0      (y0),
        .x1      (x1),
        .y1      (y1),
        .x2      (x2),
        .y2      (y2),
        .off     (srt_off),
        .out_ctl (setup_ctl),
        .prod_l  (prod_l),
        .prod_r  (prod_r),
        .den_l   (den_l),
        .den_r   (den_r),
        .xs_l    (xs_l),
        .xs_r    (xs_r),
        .neg_l   (neg_l),
        .neg_r   (neg_r),
        .row     (row)
    );

    tss_div_pipe #(.N(N), .SIDE_W(SIDE_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctl   (setup_ctl),
        .in_num   ({prod_r, prod_l}),
        .in_den   ({den_r, den_l}),
        .in_side  ({xs_l, xs_r, neg_l, neg_r, row}),
        .out_ctl  (div_ctl),
        .out_quo  (div_quo),
        .out_rem  (div_rem),
        .out_side (div_side)
    );

    tss_span_out #(.N(N)) u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ctl     (div_ctl),
        .quo_l      (div_quo[0]),
        .quo_r      (div_quo[1]),
        .rem_l      (div_rem[0]),
        .rem_r      (div_rem[1]),
        .xs_l       (div_side[SIDE_W-1 -: N]),
        .xs_r       (div_side[SIDE_W-N-1 -: N]),
        .neg_l      (div_side[N+1]),
        .neg_r      (div_side[N]),
        .row        (div_side[N-1:0]),
        .done       (done),
        .span_left  (span_left),
        .span_right (span_right),
        .span_row   (span_row),
        .span_valid (span_valid)
    );

endmodule

>>> sv/tss_sort.sv
// ---------------------------------------------------------------------------
// tss_sort
// First stage: orders the three vertices by y with three compare-swaps.
// ---------------------------------------------------------------------------
module tss_sort #(
    parameter int N = 12
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_vld,
    input  logic [N-1:0] ax,
    input  logic [N-1:0] ay,
    input  logic [N-1:0] bx,
    input  logic [N-1:0] by,
    input  logic [N-1:0] cx,
    input  logic [N-1:0] cy,
    input  logic [N-1:0] off,
    output logic         out_vld,
    output logic [N-1:0] x0,
    output logic [N-1:0] y0,
    output logic [N-1:0] x1,
    output logic [N-1:0] y1,
    output logic [N-1:0] x2,
    output logic [N-1:0] y2,
    output logic [N-1:0] out_off
);

    logic         swap_ab, swap_ac, swap_bc;
    logic [N-1:0] x0a, y0a, x1a, y1a;
    logic [N-1:0] x0b, y0b, x2b, y2b;
    logic [N-1:0] x1c, y1c, x2c, y2c;

    logic         vld_reg;
    logic [N-1:0] x0_reg, y0_reg, x1_reg, y1_reg, x2_reg, y2_reg, off_reg;

    // strict less-than: a compare-swap leaves equal y values in place
    always_comb
    begin
        swap_ab = by < ay;
        x0a     = swap_ab ? bx : ax;
        y0a     = swap_ab ? by : ay;
        x1a     = swap_ab ? ax : bx;
        y1a     = swap_ab ? ay : by;

        swap_ac = cy < y0a;
        x0b     = swap_ac ? cx  : x0a;
        y0b     = swap_ac ? cy  : y0a;
        x2b     = swap_ac ? x0a : cx;
        y2b     = swap_ac ? y0a : cy;

        swap_bc = y2b < y1a;
        x1c     = swap_bc ? x2b : x1a;
        y1c     = swap_bc ? y2b : y1a;
        x2c     = swap_bc ? x1a : x2b;
        y2c     = swap_bc ? y1a : y2b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg  <= x0b;
        y0_reg  <= y0b;
        x1_reg  <= x1c;
        y1_reg  <= y1c;
        x2_reg  <= x2c;
        y2_reg  <= y2c;
        off_reg <= off;
    end

    assign out_vld = vld_reg;
    assign x0      = x0_reg;
    assign y0      = y0_reg;
    assign x1      = x1_reg;
    assign y1      = y1_reg;
    assign x2      = x2_reg;
    assign y2      = y2_reg;
    assign out_off = off_reg;

endmodule

>>> sv/tss_edge_setup.sv
// ---------------------------------------------------------------------------
// tss_edge_setup
// Two stages: picks the half, forms |dx|, step and height for both edges,
// then multiplies |dx| by the step for each edge.
// ---------------------------------------------------------------------------
module tss_edge_setup #(
    parameter int N = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  logic [N-1:0]      x0,
    input  logic [N-1:0]      y0,
    input  logic [N-1:0]      x1,
    input  logic [N-1:0]      y1,
    input  logic [N-1:0]      x2,
    input  logic [N-1:0]      y2,
    input  logic [N-1:0]      off,
    output tss_pkg::ctl_t     out_ctl,
    output logic [2*N-1:0]    prod_l,
    output logic [2*N-1:0]    prod_r,
    output logic [N-1:0]      den_l,
    output logic [N-1:0]      den_r,
    output logic [N-1:0]      xs_l,
    output logic [N-1:0]      xs_r,
    output logic              neg_l,
    output logic              neg_r,
    output logic [N-1:0]      row
);

    import tss_pkg::*;

    localparam int PW = 2 * N;

    logic [N-1:0] total, upper, seg, rel, r_hi, r_lo, mag_l, mag_r;
    logic         lower_half, hit;

    // first register stage
    ctl_t         ctl_a_reg;
    logic [N-1:0] mag_l_reg, mag_r_reg, step_l_reg, step_r_reg;
    logic [N-1:0] den_l_a_reg, den_r_a_reg, xs_l_a_reg, xs_r_a_reg, row_a_reg;
    logic         neg_l_a_reg, neg_r_a_reg;

    // second register stage
    ctl_t         ctl_b_reg;
    logic [PW-1:0] prod_l_reg, prod_r_reg, prod_l_next, prod_r_next;
    logic [N-1:0] den_l_b_reg, den_r_b_reg, xs_l_b_reg, xs_r_b_reg, row_b_reg;
    logic         neg_l_b_reg, neg_r_b_reg;

    always_comb
    begin
        total      = y2 - y0;
        upper      = y1 - y0;
        hit        = off < total;
        // flat top forces the lower half
        lower_half = (off > upper) || (upper == '0);
        seg        = lower_half ? (y2 - y1) : upper;
        rel        = lower_half ? (off - upper) : off;
        r_hi       = lower_half ? x2 : x1;
        r_lo       = lower_half ? x1 : x0;
        mag_l      = (x2 >= x0) ? (x2 - x0) : (x0 - x2);
        mag_r      = (r_hi >= r_lo) ? (r_hi - r_lo) : (r_lo - r_hi);
    end

    assign prod_l_next = PW'(mag_l_reg) * PW'(step_l_reg);
    assign prod_r_next = PW'(mag_r_reg) * PW'(step_r_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end
        else
        begin
            ctl_a_reg.vld <= in_vld;
            ctl_a_reg.hit <= hit;
            ctl_b_reg     <= ctl_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_l_reg   <= mag_l;
        mag_r_reg   <= mag_r;
        neg_l_a_reg <= x2 < x0;
        neg_r_a_reg <= r_hi < r_lo;
        step_l_reg  <= off;
        step_r_reg  <= rel;
        den_l_a_reg <= total;
        den_r_a_reg <= seg;
        xs_l_a_reg  <= x0;
        xs_r_a_reg  <= r_lo;
        row_a_reg   <= y0 + off;

        prod_l_reg  <= prod_l_next;
        prod_r_reg  <= prod_r_next;
        den_l_b_reg <= den_l_a_reg;
        den_r_b_reg <= den_r_a_reg;
        xs_l_b_reg  <= xs_l_a_reg;
        xs_r_b_reg  <= xs_r_a_reg;
        neg_l_b_reg <= neg_l_a_reg;
        neg_r_b_reg <= neg_r_a_reg;
        row_b_reg   <= row_a_reg;
    end

    assign out_ctl = ctl_b_reg;
    assign prod_l  = prod_l_reg;
    assign prod_r  = prod_r_reg;
    assign den_l   = den_l_b_reg;
    assign den_r   = den_r_b_reg;
    assign xs_l    = xs_l_b_reg;
    assign xs_r    = xs_r_b_reg;
    assign neg_l   = neg_l_b_reg;
    assign neg_r   = neg_r_b_reg;
    assign row     = row_b_reg;

endmodule

>>> sv/tss_div_pipe.sv
// ---------------------------------------------------------------------------
// tss_div_pipe
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Assumes num < den << N, so the quotient fits in N bits.
// ---------------------------------------------------------------------------
module tss_div_pipe #(
    parameter int N      = 12,
    parameter int SIDE_W = 38
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tss_pkg::ctl_t         in_ctl,
    input  logic [1:0][2*N-1:0]   in_num,
    input  logic [1:0][N-1:0]     in_den,
    input  logic [SIDE_W-1:0]     in_side,
    output tss_pkg::ctl_t         out_ctl,
    output logic [1:0][N-1:0]     out_quo,
    output logic [1:0][N-1:0]     out_rem,
    output logic [SIDE_W-1:0]     out_side
);

    import tss_pkg::*;

    localparam int PW = 2 * N;

    ctl_t                ctl_reg  [N];
    logic [1:0][N-1:0]   rem_reg  [N];
    logic [1:0][N-1:0]   low_reg  [N];
    logic [1:0][N-1:0]   quo_reg  [N];
    logic [1:0][N-1:0]   den_reg  [N];
    logic [SIDE_W-1:0]   side_reg [N];

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        ctl_t              ctl_in;
        logic [1:0][N-1:0] rem_in, low_in, quo_in, den_in;
        logic [1:0][N-1:0] rem_next, low_next, quo_next;
        logic [1:0][N+1:0] trial;
        logic [SIDE_W-1:0] side_in;

        if (k == 0)
        begin : g_first
            // upper half of the product is already below den
            assign ctl_in  = in_ctl;
            assign rem_in  = {in_num[1][PW-1:N], in_num[0][PW-1:N]};
            assign low_in  = {in_num[1][N-1:0], in_num[0][N-1:0]};
            assign quo_in  = '0;
            assign den_in  = in_den;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign ctl_in  = ctl_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign low_in  = low_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            always_comb
            begin
                trial[l] = {1'b0, rem_in[l], low_in[l][N-1]} - {2'b00, den_in[l]};
                if (!trial[l][N+1])
                begin
                    rem_next[l] = trial[l][N-1:0];
                    quo_next[l] = {quo_in[l][N-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = {rem_in[l][N-2:0], low_in[l][N-1]};
                    quo_next[l] = {quo_in[l][N-2:0], 1'b0};
                end
                low_next[l] = {low_in[l][N-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k] <= '0;
            end
            else
            begin
                ctl_reg[k] <= ctl_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            low_reg[k]  <= low_next;
            quo_reg[k]  <= quo_next;
            den_reg[k]  <= den_in;
            side_reg[k] <= side_in;
        end
    end

    assign out_ctl  = ctl_reg[N-1];
    assign out_quo  = quo_reg[N-1];
    assign out_rem  = rem_reg[N-1];
    assign out_side = side_reg[N-1];

endmodule

>>> sv/tss_span_out.sv
// ---------------------------------------------------------------------------
// tss_span_out
// Two stages: floor correction and edge add, then left/right ordering
// and the result registers.
// ---------------------------------------------------------------------------
module tss_span_out #(
    parameter int N = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    input  tss_pkg::ctl_t in_ctl,
    input  logic [N-1:0]  quo_l,
    input  logic [N-1:0]  quo_r,
    input  logic [N-1:0]  rem_l,
    input  logic [N-1:0]  rem_r,
    input  logic [N-1:0]  xs_l,
    input  logic [N-1:0]  xs_r,
    input  logic          neg_l,
    input  logic          neg_r,
    input  logic [N-1:0]  row,
    output logic          done,
    output logic [N-1:0]  span_left,
    output logic [N-1:0]  span_right,
    output logic [N-1:0]  span_row,
    output logic          span_valid
);

    import tss_pkg::*;

    logic [N-1:0] end_l_next, end_r_next;
    logic         swap;

    ctl_t         ctl_f_reg;
    logic [N-1:0] end_l_reg, end_r_reg, row_f_reg;

    logic         done_reg, span_valid_reg;
    logic [N-1:0] span_left_reg, span_right_reg, span_row_reg;

    // negative dx: floor rounds away from zero when a remainder is left
    always_comb
    begin
        end_l_next = neg_l ? (xs_l - quo_l - N'(rem_l != '0)) : (xs_l + quo_l);
        end_r_next = neg_r ? (xs_r - quo_r - N'(rem_r != '0)) : (xs_r + quo_r);
        swap       = end_l_reg > end_r_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_f_reg      <= '0;
            done_reg       <= 1'b0;
            span_valid_reg <= 1'b0;
        end
        else
        begin
            ctl_f_reg      <= in_ctl;
            done_reg       <= ctl_f_reg.vld;
            span_valid_reg <= ctl_f_reg.vld & ctl_f_reg.hit;
        end
    end

    always_ff @(posedge clk)
    begin
        end_l_reg <= end_l_next;
        end_r_reg <= end_r_next;
        row_f_reg <= row;
        if (ctl_f_reg.hit)
        begin
            span_left_reg  <= swap ? end_r_reg : end_l_reg;
            span_right_reg <= swap ? end_l_reg : end_r_reg;
            span_row_reg   <= row_f_reg;
        end
        else
        begin
            span_left_reg  <= '0;
            span_right_reg <= '0;
            span_row_reg   <= '0;
        end
    end

    assign done       = done_reg;
    assign span_left  = span_left_reg;
    assign span_right = span_right_reg;
    assign span_row   = span_row_reg;
    assign span_valid = span_valid_reg;

endmodule

>>> sv/tss_checker.sv
// ---------------------------------------------------------------------------
// tss_checker
// Port-level checks on the triangle scanline span unit, bound to the top.
// ---------------------------------------------------------------------------
`include "triangle_scanline_span_unit_assert.svh"

module tss_checker #(
    parameter int COORD_BITS = 12
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  busy,
    input logic                  done,
    input logic [COORD_BITS-1:0] span_left,
    input logic [COORD_BITS-1:0] span_right,
    input logic [COORD_BITS-1:0] span_row,
    input logic                  span_valid
);

    `TSS_CHECK(a_never_busy, !busy, "busy raised on a stall-free pipeline")

    `TSS_CHECK_IMP(a_valid_with_done, span_valid, done, "span_valid without done")

    `TSS_CHECK_IMP(a_miss_reads_zero, done && !span_valid, (span_left == '0) && (span_right == '0) && (span_row == '0), "invalid row with nonzero fields")

    `TSS_CHECK_IMP(a_span_ordered, done && span_valid, span_left <= span_right, "span ends out of order")

endmodule

bind triangle_scanline_span_unit tss_checker #(.COORD_BITS(COORD_BITS)) u_tss_checker (.*);
